/* rtl/fir_filter_direct_form_core_macros.svh */
// ----------------------------------------------------------------------------
// FIR filter core assertion macros
// Shared concurrent assertion forms for the filter RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_DIRECT_FORM_CORE_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FIR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define FIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fir_pkg.sv */
// ----------------------------------------------------------------------------
// FIR filter package
// Tap count, field widths, derived widths and shared types.
// ----------------------------------------------------------------------------
package fir_pkg;

    // Filter length, 1 to 64
    localparam int TAPS   = 64;

    // Field widths
    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int TIX_W  = 6;
    localparam int FRAC_W = 15;

    // Derived widths
    localparam int IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int Q_W    = ACC_W - FRAC_W;

    // Word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef logic                     t_kind;
    typedef logic signed [SMP_W-1:0]  t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [TIX_W-1:0]         t_tix;

endpackage

/* rtl/fir_if.sv */
// ----------------------------------------------------------------------------
// FIR filter channels
// Valid/ready channels for input words and filtered output words.
// ----------------------------------------------------------------------------
interface fir_in_if;
    logic             valid;
    logic             ready;
    fir_pkg::t_kind   kind;
    fir_pkg::t_sample sample_in;
    fir_pkg::t_tix    tap_index;
    fir_pkg::t_coef   tap_value;

    modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
    modport sink   (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface fir_out_if;
    logic             valid;
    logic             ready;
    fir_pkg::t_sample left_out;
    fir_pkg::t_sample right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

/* rtl/fir_filter_direct_form_core.sv */
// A sample word passes the RUN, FLUSH and SCALE states before its output word is
// registered, and SCALE waits while an earlier output word is still held. The single
// shared multiply-accumulate unit visits one tap per cycle. Input is taken in IDLE only.
// Reset (synchronous, active low) empties the delay line through its fill count
// and clears the sequencer and output valid; coefficients stay unknown until written.
// ----------------------------------------------------------------------------
// FIR filter core
// Direct-form FIR: circular delay line, coefficient RAM, one pipelined MAC
// stepped over all taps, then scale by 2^-15 toward zero and saturate.
// ----------------------------------------------------------------------------
`include "fir_filter_direct_form_core_macros.svh"

module fir_filter_direct_form_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fir_in_if.sink    i_in,
    fir_out_if.source o_out
);

    localparam int IDX_W  = fir_pkg::IDX_W;
    localparam int CNT_W  = fir_pkg::CNT_W;
    localparam int ACC_W  = fir_pkg::ACC_W;
    localparam int PROD_W = fir_pkg::PROD_W;
    localparam int Q_W    = fir_pkg::Q_W;

    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(fir_pkg::TAPS - 1);
    localparam logic [CNT_W-1:0]        FULL_CNT = CNT_W'(fir_pkg::TAPS);
    localparam logic signed [ACC_W-1:0] BIAS     = ACC_W'((2 ** fir_pkg::FRAC_W) - 1);
    localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'(32767);
    localparam logic signed [Q_W-1:0]   Q_MIN    = Q_W'(-32768);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_SCALE = 4'b1000
    } t_state;

    // Storage
    fir_pkg::t_sample r_dmem [fir_pkg::TAPS];
    fir_pkg::t_coef   r_cmem [fir_pkg::TAPS];

    // Sequencer and pipeline control
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_wp;
    logic [IDX_W-1:0]    r_rp;
    logic [IDX_W-1:0]    r_j;
    logic [CNT_W-1:0]    r_fill;
    logic                r_s1, r_l1, r_v1;
    logic                r_s2, r_l2;
    logic                r_ovalid;

    // Datapath
    fir_pkg::t_sample    r_dq;
    fir_pkg::t_coef      r_cq;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    fir_pkg::t_sample    r_out;

    logic                n_in_acc;
    logic                n_smp_acc;
    logic                n_coef_acc;
    logic                n_out_acc;
    logic signed [ACC_W-1:0] n_bias;
    logic signed [Q_W-1:0]   n_q;
    fir_pkg::t_sample    n_y;

    // Handshake
    assign i_in.ready  = (r_state == ST_IDLE);
    assign n_in_acc    = i_in.valid && i_in.ready;
    assign n_smp_acc   = n_in_acc && (i_in.kind == fir_pkg::KIND_SAMPLE);
    assign n_coef_acc  = n_in_acc && (i_in.kind == fir_pkg::KIND_COEF)
                         && (int'(i_in.tap_index) < fir_pkg::TAPS);
    assign n_out_acc   = o_out.valid && o_out.ready;

    assign o_out.valid     = r_ovalid;
    assign o_out.left_out  = r_out;
    assign o_out.right_out = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (n_smp_acc) n_state = ST_RUN;
            ST_RUN:   if (r_j == LAST_IDX) n_state = ST_FLUSH;
            ST_FLUSH: if (r_s2 && r_l2) n_state = ST_SCALE;
            ST_SCALE: if (!r_ovalid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Scale by 2^-15 toward zero, then saturate
    always_comb begin
        n_bias = r_acc + (r_acc[ACC_W-1] ? BIAS : '0);
        n_q    = Q_W'(n_bias >>> fir_pkg::FRAC_W);
        if (n_q > Q_MAX) begin
            n_y = fir_pkg::t_sample'(Q_MAX[fir_pkg::SMP_W-1:0]);
        end else if (n_q < Q_MIN) begin
            n_y = fir_pkg::t_sample'(Q_MIN[fir_pkg::SMP_W-1:0]);
        end else begin
            n_y = n_q[fir_pkg::SMP_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_rp     <= '0;
            r_j      <= '0;
            r_fill   <= '0;
            r_s1     <= 1'b0;
            r_l1     <= 1'b0;
            r_s2     <= 1'b0;
            r_l2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take a sample: advance the write pointer and, below full, the fill count
            if (n_smp_acc) begin
                r_rp <= r_wp;
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
                r_j  <= '0;
                if (r_fill != FULL_CNT) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (r_state == ST_RUN) begin
                // Step one tap back in time
                r_j  <= r_j + 1'b1;
                r_rp <= (r_rp == '0) ? LAST_IDX : r_rp - 1'b1;
            end

            // Pipeline valid and last-tap marks
            r_s1 <= (r_state == ST_RUN);
            r_l1 <= (r_state == ST_RUN) && (r_j == LAST_IDX);
            r_s2 <= r_s1;
            r_l2 <= r_l1;

            // Output word register
            if ((r_state == ST_SCALE) && !r_ovalid) begin
                r_ovalid <= 1'b1;
            end else if (n_out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (n_smp_acc) begin
            r_dmem[r_wp] <= i_in.sample_in;
        end
        if (n_coef_acc) begin
            r_cmem[IDX_W'(i_in.tap_index)] <= i_in.tap_value;
        end
    end

    // Registered memory reads, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_dq   <= r_dmem[r_rp];
        r_cq   <= r_cmem[r_j];
        r_v1   <= (CNT_W'(r_j) < r_fill);
        // Keep the product signed: zero it for taps not yet filled
        if (r_v1) begin
            r_prod <= r_dq * r_cq;
        end else begin
            r_prod <= '0;
        end
        if (n_smp_acc) begin
            r_acc <= '0;
        end else if (r_s2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if ((r_state == ST_SCALE) && !r_ovalid) begin
            r_out <= n_y;
        end
    end

    // Checks
    `FIR_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL_CNT,
                     "fill count beyond tap count")
    `FIR_ASSERT_SAME(a_mac_busy, i_clk, i_rst_n, r_s2,
                     (r_state == ST_RUN) || (r_state == ST_FLUSH),
                     "MAC active outside run")
    `FIR_ASSERT_NEXT(a_smp_start, i_clk, i_rst_n, n_smp_acc,
                     (r_state == ST_RUN) && (r_j == '0) && (r_acc == '0),
                     "sample word did not start a run")
    `FIR_ASSERT_NEXT(a_scale_out, i_clk, i_rst_n, (r_state == ST_SCALE) && !r_ovalid,
                     r_ovalid && (r_state == ST_IDLE), "scaled word not presented")

endmodule
